### rtl/qlrs_pkg.sv
package qlrs_pkg;

    localparam int CW     = 32;               // coefficient width
    localparam int FB     = 16;               // fraction bits
    localparam int NB_W   = CW + FB + 1;      // signed width of -coef * 2^FB
    localparam int DEN_W  = CW + 1;           // divisor magnitude width
    localparam int DISC_W = 2 * CW + 3;       // signed discriminant width
    localparam int DM_W   = DISC_W - 1;       // discriminant magnitude width
    localparam int RAD_W  = DM_W + 2 * FB;    // scaled radicand width
    localparam int ROOT_W = RAD_W / 2;        // square root width
    localparam int NUM_W  = ROOT_W + 1;       // dividend magnitude width

    localparam logic [1:0] FUNC_LINEAR = 2'd1;
    localparam logic [1:0] FUNC_QUAD   = 2'd2;

    typedef struct packed {
        logic [1:0]           func;
        logic signed [CW-1:0] coef_square;
        logic signed [CW-1:0] coef_linear;
        logic signed [CW-1:0] coef_constant;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           root_count;
        logic signed [CW-1:0] root_first;
        logic signed [CW-1:0] root_second;
        logic                 saturated;
    } t_out_item;

    // Per-item control and operands carried alongside the square root
    typedef struct packed {
        logic [1:0]             count;
        logic                   lin_zero;
        logic signed [NB_W-1:0] nb;
        logic [DEN_W-1:0]       den;
        logic                   den_neg;
    } t_side;

    // Control carried alongside the dividers
    typedef struct packed {
        logic [1:0] count;
        logic       lin_zero;
        logic       neg1;
        logic       neg2;
    } t_div_ctl;

    // Clip a quotient magnitude to the signed range and apply the sign
    function automatic logic [CW:0] clip_root(input logic [NUM_W-1:0] q, input logic neg);
        logic [NUM_W-1:0] lim;
        logic             sat;
        logic [CW-1:0]    m;
        lim = neg ? (NUM_W'(1) << (CW - 1)) : ((NUM_W'(1) << (CW - 1)) - NUM_W'(1));
        sat = q > lim;
        m   = sat ? lim[CW-1:0] : q[CW-1:0];
        return {sat, neg ? (CW'(0) - m) : m};
    endfunction

endpackage

### rtl/qlrs_front.sv
module qlrs_front import qlrs_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  t_in_item       i_item,
    output logic           o_valid,
    output t_side          o_side,
    output logic [DM_W-1:0] o_rad
);

    logic            r1_v;
    t_in_item        r1_item;
    logic            r2_v;
    logic [2*CW-1:0] r2_bb;
    logic [2*CW-1:0] r2_ac;
    logic            r2_ac_neg;
    logic            r2_quad;
    logic            r2_lin;
    t_side           r2_side;
    logic            r3_v;
    t_side           r3_side;
    logic [DM_W-1:0] r3_rad;

    logic                   a_neg, b_neg, c_neg;
    logic [CW-1:0]          a_mag, b_mag, c_mag;
    logic signed [NB_W-1:0] nb_b, nb_c;
    t_side                  n2_side;
    logic signed [DISC_W-1:0] disc;
    logic [DM_W-1:0]        disc_mag;
    t_side                  n3_side;

    // Magnitudes and per-degree dividend and divisor
    always_comb begin
        a_neg = r1_item.coef_square[CW-1];
        b_neg = r1_item.coef_linear[CW-1];
        c_neg = r1_item.coef_constant[CW-1];
        a_mag = a_neg ? (CW'(0) - r1_item.coef_square) : r1_item.coef_square;
        b_mag = b_neg ? (CW'(0) - r1_item.coef_linear) : r1_item.coef_linear;
        c_mag = c_neg ? (CW'(0) - r1_item.coef_constant) : r1_item.coef_constant;
        nb_b = -($signed({{(FB+1){b_neg}}, r1_item.coef_linear}) <<< FB);
        nb_c = -($signed({{(FB+1){c_neg}}, r1_item.coef_constant}) <<< FB);
        n2_side.count    = 2'd0;
        n2_side.lin_zero = (b_mag == '0) || (c_mag == '0);
        if (r1_item.func == FUNC_LINEAR) begin
            n2_side.nb      = nb_c;
            n2_side.den     = {1'b0, b_mag};
            n2_side.den_neg = b_neg;
        end else begin
            n2_side.nb      = nb_b;
            n2_side.den     = {a_mag, 1'b0};
            n2_side.den_neg = a_neg;
        end
    end

    // Discriminant and root count
    always_comb begin
        disc = r2_ac_neg ? ($signed({3'b000, r2_bb}) + $signed({1'b0, r2_ac, 2'b00}))
                         : ($signed({3'b000, r2_bb}) - $signed({1'b0, r2_ac, 2'b00}));
        disc_mag = disc[DISC_W-1] ? DM_W'(-disc) : DM_W'(disc);
        n3_side = r2_side;
        if (r2_lin) begin
            n3_side.count = 2'd1;
        end else if (r2_quad && !disc[DISC_W-1]) begin
            n3_side.count = (disc == '0) ? 2'd1 : 2'd2;
        end else begin
            n3_side.count = 2'd0;
        end
        n3_side.lin_zero = r2_lin && r2_side.lin_zero;
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r1_item   <= i_item;
        r2_bb     <= b_mag * b_mag;
        r2_ac     <= a_mag * c_mag;
        r2_ac_neg <= a_neg ^ c_neg;
        r2_quad   <= (r1_item.func == FUNC_QUAD) && (a_mag != '0);
        r2_lin    <= r1_item.func == FUNC_LINEAR;
        r2_side   <= n2_side;
        r3_side   <= n3_side;
        r3_rad    <= (n3_side.count == 2'd2) ? disc_mag : '0;
    end

    assign o_valid = r3_v;
    assign o_side  = r3_side;
    assign o_rad   = r3_rad;

endmodule

### rtl/qlrs_sqrt.sv
module qlrs_sqrt import qlrs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_side             i_side,
    input  logic [DM_W-1:0]   i_rad,
    output logic              o_valid,
    output t_side             o_side,
    output logic [ROOT_W-1:0] o_root
);

    localparam int REM_W = ROOT_W + 2;

    logic              s_v    [0:ROOT_W];
    t_side             s_side [0:ROOT_W];
    logic [RAD_W-1:0]  s_rad  [0:ROOT_W];
    logic [REM_W-1:0]  s_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] s_root [0:ROOT_W];

    assign s_v[0]    = i_valid;
    assign s_side[0] = i_side;
    assign s_rad[0]  = {i_rad, {(2*FB){1'b0}}};
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;

    // One root bit per stage, most significant first
    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic             take;

        always_comb begin
            rem_sh = {s_rem[k][REM_W-3:0], s_rad[k][RAD_W-1-2*k -: 2]};
            trial  = {s_root[k], 2'b01};
            take   = rem_sh >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                s_v[k+1] <= 1'b0;
            end else begin
                s_v[k+1] <= s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            s_side[k+1] <= s_side[k];
            s_rad[k+1]  <= s_rad[k];
            s_rem[k+1]  <= take ? (rem_sh - trial) : rem_sh;
            s_root[k+1] <= {s_root[k][ROOT_W-2:0], take};
        end
    end

    assign o_valid = s_v[ROOT_W];
    assign o_side  = s_side[ROOT_W];
    assign o_root  = s_root[ROOT_W];

endmodule

### rtl/qlrs_div_lane.sv
module qlrs_div_lane import qlrs_pkg::*; (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);

    localparam int REM_W = DEN_W + 1;

    logic [NUM_W-1:0] s_num [0:NUM_W];
    logic [DEN_W-1:0] s_den [0:NUM_W];
    logic [REM_W-1:0] s_rem [0:NUM_W];
    logic [NUM_W-1:0] s_quo [0:NUM_W];

    assign s_num[0] = i_num;
    assign s_den[0] = i_den;
    assign s_rem[0] = '0;
    assign s_quo[0] = '0;

    // Restoring division, one quotient bit per stage
    for (genvar j = 0; j < NUM_W; j++) begin : g_stage
        logic [REM_W-1:0] rem_sh;
        logic             take;

        always_comb begin
            rem_sh = {s_rem[j][REM_W-2:0], s_num[j][NUM_W-1-j]};
            take   = rem_sh >= {1'b0, s_den[j]};
        end

        always_ff @(posedge i_clk) begin
            s_num[j+1] <= s_num[j];
            s_den[j+1] <= s_den[j];
            s_rem[j+1] <= take ? (rem_sh - {1'b0, s_den[j]}) : rem_sh;
            s_quo[j+1] <= {s_quo[j][NUM_W-2:0], take};
        end
    end

    assign o_quo = s_quo[NUM_W];

endmodule

### rtl/quadratic_linear_root_solver.sv
// Results pass through the front, square root, dividend, divider and output registers;
// one transaction may start every cycle (busy stays low), since every stage is a plain register stage.
// Depth is set by the square root (one bit per stage) and the two dividers (one bit per stage).
// Reset (synchronous, active low) clears all valid bits; nothing in flight survives it.
// The receiver cannot stall: each result strobe lasts one cycle.
module quadratic_linear_root_solver import qlrs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_valid,
    output t_out_item o_item
);

    logic              fr_v;
    t_side             fr_side;
    logic [DM_W-1:0]   fr_rad;
    logic              sq_v;
    t_side             sq_side;
    logic [ROOT_W-1:0] sq_root;

    logic signed [NUM_W:0] n1, n2;
    logic                  r_e_v;
    t_div_ctl              r_e_ctl;
    t_div_ctl              n_e_ctl;
    logic [NUM_W-1:0]      r_e_num1, r_e_num2;
    logic [DEN_W-1:0]      r_e_den;
    logic [NUM_W-1:0]      quo1, quo2;

    logic     d_v   [0:NUM_W];
    t_div_ctl d_ctl [0:NUM_W];

    logic      r_out_v;
    t_out_item r_out_item;
    t_out_item n_out_item;
    logic [CW:0] c1, c2;

    assign busy = 1'b0;

    qlrs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_item  (i_item),
        .o_valid (fr_v),
        .o_side  (fr_side),
        .o_rad   (fr_rad)
    );

    qlrs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_v),
        .i_side  (fr_side),
        .i_rad   (fr_rad),
        .o_valid (sq_v),
        .o_side  (sq_side),
        .o_root  (sq_root)
    );

    // Form both dividends and their result signs
    always_comb begin
        n1 = (NUM_W+1)'(sq_side.nb) - $signed({2'b00, sq_root});
        n2 = (NUM_W+1)'(sq_side.nb) + $signed({2'b00, sq_root});
        n_e_ctl.count    = sq_side.count;
        n_e_ctl.lin_zero = sq_side.lin_zero;
        n_e_ctl.neg1     = n1[NUM_W] ^ sq_side.den_neg;
        n_e_ctl.neg2     = n2[NUM_W] ^ sq_side.den_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else begin
            r_e_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_ctl  <= n_e_ctl;
        r_e_num1 <= n1[NUM_W] ? NUM_W'(-n1) : NUM_W'(n1);
        r_e_num2 <= n2[NUM_W] ? NUM_W'(-n2) : NUM_W'(n2);
        r_e_den  <= sq_side.den;
    end

    qlrs_div_lane u_div1 (
        .i_clk (i_clk),
        .i_num (r_e_num1),
        .i_den (r_e_den),
        .o_quo (quo1)
    );

    qlrs_div_lane u_div2 (
        .i_clk (i_clk),
        .i_num (r_e_num2),
        .i_den (r_e_den),
        .o_quo (quo2)
    );

    // Carry valid and control alongside the dividers
    assign d_v[0]   = r_e_v;
    assign d_ctl[0] = r_e_ctl;
    for (genvar j = 0; j < NUM_W; j++) begin : g_ctl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                d_v[j+1] <= 1'b0;
            end else begin
                d_v[j+1] <= d_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            d_ctl[j+1] <= d_ctl[j];
        end
    end

    // Clip, select and drop unused roots
    always_comb begin
        c1 = clip_root(quo1, d_ctl[NUM_W].neg1);
        c2 = clip_root(quo2, d_ctl[NUM_W].neg2);
        n_out_item.root_count  = d_ctl[NUM_W].count;
        n_out_item.root_first  = '0;
        n_out_item.root_second = '0;
        n_out_item.saturated   = 1'b0;
        if (d_ctl[NUM_W].count != 2'd0 && !d_ctl[NUM_W].lin_zero) begin
            n_out_item.root_first = c1[CW-1:0];
            n_out_item.saturated  = c1[CW];
        end
        if (d_ctl[NUM_W].count == 2'd2) begin
            n_out_item.root_second = c2[CW-1:0];
            n_out_item.saturated   = c1[CW] | c2[CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= d_v[NUM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_valid = r_out_v;
    assign o_item  = r_out_item;

endmodule
